// ===== design/nvp_pkg.sv =====
`default_nettype none

package nvp_pkg;

  // Fixed-point format and input width.
  localparam int FRAC_BITS   = 8;
  localparam int TARGET_BITS = 14;

  // Register and result field widths.
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 14;
  localparam int UPPER_W  = 14;
  localparam int LOWER_W  = 15;
  localparam int DBAND_W  = 8;
  localparam int NPOS_W   = 15;
  localparam int DOUT_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Internal datapath widths, all signed.
  localparam int POS_W    = LOWER_W + FRAC_BITS;
  localparam int TGT_FX_W = TARGET_BITS + FRAC_BITS + 1;
  localparam int PB_W     = (TGT_FX_W > POS_W) ? TGT_FX_W : POS_W;
  localparam int ERR_W    = PB_W + 1;
  localparam int D1_W     = ERR_W + 1;
  localparam int D2_W     = ERR_W + 2;
  localparam int PROD_W   = D2_W + GAIN_W + 1;
  localparam int SUM_W    = PROD_W + 2;
  localparam int INC_W    = SUM_W - GAIN_W;
  localparam int DRV_W    = 32;
  localparam int DSUM_W   = ((INC_W > DRV_W) ? INC_W : DRV_W) + 1;
  localparam int PSUM_W   = ((PB_W > DRV_W) ? PB_W : DRV_W) + 1;
  localparam int IDRV_W   = DRV_W - FRAC_BITS;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_DRIVE_LIMIT = 3'd3,
    REG_POS_UPPER   = 3'd4,
    REG_POS_LOWER   = 3'd5,
    REG_DEAD_BAND   = 3'd6
  } nvp_reg_e;

  // Reset values of the registers.
  localparam logic [GAIN_W-1:0]         GAIN_PROP_RST   = 16'd6554;
  localparam logic [GAIN_W-1:0]         GAIN_INTEG_RST  = 16'd328;
  localparam logic [GAIN_W-1:0]         GAIN_DERIV_RST  = 16'd3277;
  localparam logic [LIMIT_W-1:0]        DRIVE_LIMIT_RST = 14'd3000;
  localparam logic [UPPER_W-1:0]        POS_UPPER_RST   = 14'd8250;
  localparam logic signed [LOWER_W-1:0] POS_LOWER_RST   = -15'sd250;
  localparam logic [DBAND_W-1:0]        DEAD_BAND_RST   = 8'd1;

  typedef struct packed {
    logic [GAIN_W-1:0]         gain_prop;
    logic [GAIN_W-1:0]         gain_integ;
    logic [GAIN_W-1:0]         gain_deriv;
    logic [LIMIT_W-1:0]        drive_limit;
    logic [UPPER_W-1:0]        pos_upper;
    logic signed [LOWER_W-1:0] pos_lower;
    logic [DBAND_W-1:0]        dead_band;
  } nvp_cfg_t;

  // Loop state carried from one word to the next.
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [DRV_W-1:0] last_drive;
    logic signed [ERR_W-1:0] err_prev;
    logic signed [ERR_W-1:0] err_prev2;
  } nvp_state_t;

endpackage

`default_nettype wire

// ===== design/needle_velocity_pid_unit.sv =====
// Flow: an accepted word passes the input register and then the result
// register, where it waits until it is taken.
// Throughput: one word per cycle while the output does not stall; the whole
// update is combinational between the input and result registers, which also
// closes the state loop. Reset clears position, drive and error history to
// zero, loads the register defaults and empties both pipeline stages.
`default_nettype none

module needle_velocity_pid_unit import nvp_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Configuration write port
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0]           cfg_data_i,
  // Input channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [TARGET_BITS-1:0]     target_rpm_i,
  // Output channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [NPOS_W-1:0]        needle_pos_o,
  output logic signed [DOUT_W-1:0]        drive_out_o
);

  nvp_cfg_t                    cfg_q;
  nvp_state_t                  state_q;
  nvp_state_t                  state_d;
  logic                        in_valid_q;
  logic [TARGET_BITS-1:0]      target_q;
  logic                        out_valid_q;
  logic signed [NPOS_W-1:0]    npos_q;
  logic signed [NPOS_W-1:0]    npos_d;
  logic signed [DOUT_W-1:0]    dout_q;
  logic signed [DOUT_W-1:0]    dout_d;
  logic                        out_free;
  logic                        advance;
  logic                        in_take;

  // Handshake: the result stage frees up when empty or when its word is taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop   <= GAIN_PROP_RST;
      cfg_q.gain_integ  <= GAIN_INTEG_RST;
      cfg_q.gain_deriv  <= GAIN_DERIV_RST;
      cfg_q.drive_limit <= DRIVE_LIMIT_RST;
      cfg_q.pos_upper   <= POS_UPPER_RST;
      cfg_q.pos_lower   <= POS_LOWER_RST;
      cfg_q.dead_band   <= DEAD_BAND_RST;
    end else if (cfg_we_i) begin
      case (nvp_reg_e'(cfg_idx_i))
        REG_GAIN_PROP:   cfg_q.gain_prop   <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_INTEG:  cfg_q.gain_integ  <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_DERIV:  cfg_q.gain_deriv  <= cfg_data_i[GAIN_W-1:0];
        REG_DRIVE_LIMIT: cfg_q.drive_limit <= cfg_data_i[LIMIT_W-1:0];
        REG_POS_UPPER:   cfg_q.pos_upper   <= cfg_data_i[UPPER_W-1:0];
        REG_POS_LOWER:   cfg_q.pos_lower   <= $signed(cfg_data_i[LOWER_W-1:0]);
        REG_DEAD_BAND:   cfg_q.dead_band   <= cfg_data_i[DBAND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Update datapath.
  nvp_update u_update (
    .target_i     (target_q),
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .needle_pos_o (npos_d),
    .drive_out_o  (dout_d)
  );

  // Valid flags and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      target_q <= target_rpm_i;
    end
    if (advance) begin
      npos_q <= npos_d;
      dout_q <= dout_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign needle_pos_o = npos_q;
  assign drive_out_o  = dout_q;

endmodule

`default_nettype wire

// ===== design/nvp_update.sv =====
`default_nettype none

module nvp_update import nvp_pkg::*; (
  input  wire logic [TARGET_BITS-1:0]  target_i,
  input  wire nvp_cfg_t                cfg_i,
  input  wire nvp_state_t              state_i,
  output nvp_state_t                   state_o,
  output logic signed [NPOS_W-1:0]     needle_pos_o,
  output logic signed [DOUT_W-1:0]     drive_out_o
);

  localparam logic signed [SUM_W-1:0]  RoundHalf = SUM_W'(32768);
  localparam logic signed [DSUM_W-1:0] DrvMin =
    DSUM_W'($signed({1'b1, {(DRV_W-1){1'b0}}}));
  localparam logic signed [IDRV_W-1:0] IdrvMin = IDRV_W'(-32768);

  logic signed [TGT_FX_W-1:0] tgt_fx;
  logic signed [ERR_W-1:0]    err;
  logic [ERR_W-1:0]           mag;
  logic [ERR_W-1:0]           db_fx;
  logic                       snap;
  logic signed [D1_W-1:0]     d1;
  logic signed [D2_W-1:0]     d2;
  logic signed [GAIN_W:0]     gp_s;
  logic signed [GAIN_W:0]     gi_s;
  logic signed [GAIN_W:0]     gd_s;
  logic signed [PROD_W-1:0]   p_prop;
  logic signed [PROD_W-1:0]   p_integ;
  logic signed [PROD_W-1:0]   p_deriv;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    rnd;
  logic signed [INC_W-1:0]    inc;
  logic signed [DSUM_W-1:0]   dsum;
  logic signed [DSUM_W-1:0]   lim;
  logic signed [DSUM_W-1:0]   drive_c;
  logic signed [DRV_W-1:0]    drive;
  logic signed [PB_W-1:0]     pos_base;
  logic signed [PSUM_W-1:0]   psum;
  logic signed [PSUM_W-1:0]   hi;
  logic signed [PSUM_W-1:0]   lo;
  logic signed [PSUM_W-1:0]   pos_c;
  logic signed [POS_W-1:0]    pos_new;
  logic signed [IDRV_W-1:0]   idrv;

  // Error against the current position and the deadband test on its magnitude.
  always_comb begin
    tgt_fx = $signed({1'b0, target_i, {FRAC_BITS{1'b0}}});
    err    = ERR_W'(tgt_fx) - ERR_W'(state_i.position);
    mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    db_fx  = ERR_W'({cfg_i.dead_band, {FRAC_BITS{1'b0}}});
    snap   = (mag < db_fx);
  end

  // Velocity-form increment, rounded to nearest with ties toward plus infinity.
  always_comb begin
    d1      = D1_W'(err) - D1_W'(state_i.err_prev);
    d2      = D2_W'(err) - (D2_W'(state_i.err_prev) <<< 1) + D2_W'(state_i.err_prev2);
    gp_s    = $signed({1'b0, cfg_i.gain_prop});
    gi_s    = $signed({1'b0, cfg_i.gain_integ});
    gd_s    = $signed({1'b0, cfg_i.gain_deriv});
    p_prop  = PROD_W'(gp_s) * PROD_W'(d1);
    p_integ = PROD_W'(gi_s) * PROD_W'(err);
    p_deriv = PROD_W'(gd_s) * PROD_W'(d2);
    sum     = SUM_W'(p_prop) + SUM_W'(p_integ) + SUM_W'(p_deriv);
    rnd     = sum + RoundHalf;
    inc     = $signed(rnd[SUM_W-1:GAIN_W]);
  end

  // New drive: clamped above at the limit, saturated below at the 32-bit minimum.
  always_comb begin
    dsum = DSUM_W'(state_i.last_drive) + DSUM_W'(inc);
    lim  = $signed(DSUM_W'({cfg_i.drive_limit, {FRAC_BITS{1'b0}}}));
    if (dsum > lim) begin
      drive_c = lim;
    end else if (dsum < DrvMin) begin
      drive_c = DrvMin;
    end else begin
      drive_c = dsum;
    end
    drive = $signed(drive_c[DRV_W-1:0]);
  end

  // Position update, upper bound first and then lower bound.
  always_comb begin
    pos_base = snap ? PB_W'(tgt_fx) : PB_W'(state_i.position);
    psum     = PSUM_W'(pos_base) + PSUM_W'(drive);
    hi       = $signed(PSUM_W'({cfg_i.pos_upper, {FRAC_BITS{1'b0}}}));
    lo       = PSUM_W'($signed({cfg_i.pos_lower, {FRAC_BITS{1'b0}}}));
    pos_c    = psum;
    if (pos_c > hi) begin
      pos_c = hi;
    end
    if (pos_c < lo) begin
      pos_c = lo;
    end
    pos_new = $signed(pos_c[POS_W-1:0]);
  end

  // Next state and the integer parts shown at the outputs.
  always_comb begin
    state_o.position   = pos_new;
    state_o.last_drive = drive;
    state_o.err_prev   = err;
    state_o.err_prev2  = state_i.err_prev;
    needle_pos_o       = $signed(pos_new[POS_W-1:FRAC_BITS]);
    idrv               = $signed(drive[DRV_W-1:FRAC_BITS]);
    if (idrv < IdrvMin) begin
      drive_out_o = DOUT_W'(IdrvMin);
    end else begin
      drive_out_o = DOUT_W'(idrv);
    end
  end

endmodule

`default_nettype wire

// ===== sim/needle_velocity_pid_unit_test.sv =====
`timescale 1ns / 100ps

module needle_velocity_pid_unit_test import nvp_pkg::*;;

  localparam int     CYCLE_LIMIT   = 200000;
  localparam int     SETTLE_CYCLES = 6;
  localparam int     IDLE_MAX      = 17;
  localparam int     LONG_HOLD     = 200;
  localparam int     RANDOM_PHASES = 6;
  localparam int     WORDS_PER_PHASE = 80;
  localparam int     TARGET_MAX    = (1 << TARGET_BITS) - 1;
  localparam longint DRIVE_FLOOR   = -(64'sd1 <<< 31);
  localparam longint DOUT_FLOOR    = -(64'sd1 <<< (DOUT_W - 1));
  // Index with no register behind it; writes there must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE = 3'd7;

  typedef struct packed {
    logic signed [NPOS_W-1:0] needle_pos;
    logic signed [DOUT_W-1:0] drive_out;
  } pid_result_t;

  // Tracks the loop state of the needle controller and holds the results
  // still owed by the block, oldest first.
  class pid_scoreboard;
    logic [GAIN_W-1:0] kp, ki, kd;
    longint            drive_cap, upper_bound, lower_bound, snap_band;
    longint            pos_fx, drive_fx, err_last, err_last2;
    pid_result_t       due_q[$];
    int                n_targets, n_results, n_errors;

    function new();
      kp          = GAIN_PROP_RST;
      ki          = GAIN_INTEG_RST;
      kd          = GAIN_DERIV_RST;
      drive_cap   = longint'(DRIVE_LIMIT_RST);
      upper_bound = longint'(POS_UPPER_RST);
      lower_bound = longint'(POS_LOWER_RST);
      snap_band   = longint'(DEAD_BAND_RST);
      pos_fx      = 0;
      drive_fx    = 0;
      err_last    = 0;
      err_last2   = 0;
      n_targets   = 0;
      n_results   = 0;
      n_errors    = 0;
    endfunction

    // Only the low bits of each register count; the lower bound is signed.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_GAIN_PROP:   kp = data;
        REG_GAIN_INTEG:  ki = data;
        REG_GAIN_DERIV:  kd = data;
        REG_DRIVE_LIMIT: drive_cap = longint'(data[LIMIT_W-1:0]);
        REG_POS_UPPER:   upper_bound = longint'(data[UPPER_W-1:0]);
        REG_POS_LOWER:   lower_bound = longint'($signed(data[LOWER_W-1:0]));
        REG_DEAD_BAND:   snap_band = longint'(data[DBAND_W-1:0]);
        default: ;
      endcase
    endfunction

    // One control tick for an accepted target word.
    function void note_target(logic [TARGET_BITS-1:0] tgt);
      longint      tgt_fx, err, mag, acc, inc, drv, npos, ndrv;
      pid_result_t r;
      tgt_fx = longint'(tgt) <<< FRAC_BITS;
      err    = tgt_fx - pos_fx;
      mag    = (err < 0) ? -err : err;
      // The snap uses the error before the update; the increment does too.
      if (mag < (snap_band <<< FRAC_BITS))
        pos_fx = tgt_fx;
      acc = longint'(kp) * (err - err_last) + longint'(ki) * err
          + longint'(kd) * (err - 2 * err_last + err_last2);
      inc = (acc + (64'sd1 <<< 15)) >>> 16;
      drv = drive_fx + inc;
      if (drv > (drive_cap <<< FRAC_BITS))
        drv = drive_cap <<< FRAC_BITS;
      if (drv < DRIVE_FLOOR)
        drv = DRIVE_FLOOR;
      // Upper bound first, then lower bound.
      pos_fx = pos_fx + drv;
      if (pos_fx > (upper_bound <<< FRAC_BITS))
        pos_fx = upper_bound <<< FRAC_BITS;
      if (pos_fx < (lower_bound <<< FRAC_BITS))
        pos_fx = lower_bound <<< FRAC_BITS;
      drive_fx  = drv;
      err_last2 = err_last;
      err_last  = err;
      npos = pos_fx >>> FRAC_BITS;
      ndrv = drv >>> FRAC_BITS;
      if (ndrv < DOUT_FLOOR)
        ndrv = DOUT_FLOOR;
      r.needle_pos = npos[NPOS_W-1:0];
      r.drive_out  = ndrv[DOUT_W-1:0];
      due_q.push_back(r);
      n_targets++;
    endfunction

    function void report(string what, longint want, longint got);
      n_errors++;
      if (n_errors <= 10)
        $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                 $time, what, n_results, want, got);
    endfunction

    function void check_result(logic signed [NPOS_W-1:0] pos,
                               logic signed [DOUT_W-1:0] drv);
      pid_result_t want;
      n_results++;
      if (due_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: result word with nothing expected (pos %0d, drive %0d)",
                   $time, pos, drv);
        return;
      end
      want = due_q.pop_front();
      if (want.needle_pos !== pos)
        report("needle_pos", want.needle_pos, pos);
      if (want.drive_out !== drv)
        report("drive_out", want.drive_out, drv);
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [TARGET_BITS-1:0]   target_rpm_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [NPOS_W-1:0] needle_pos_o;
  logic signed [DOUT_W-1:0] drive_out_o;

  pid_scoreboard sb;
  int            send_idle_max;
  int            sink_idle_max;
  bit            hold_request;
  int            cycle_count;
  int            n_settings;
  int            walk_tgt;

  needle_velocity_pid_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .target_rpm_i (target_rpm_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .needle_pos_o (needle_pos_o),
    .drive_out_o  (drive_out_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watchdog on the total run length.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offer one target word after a random gap and wait until it is taken.
  task automatic offer_target(input logic [TARGET_BITS-1:0] tgt);
    int gap;
    gap = $urandom_range(send_idle_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    target_rpm_i <= tgt;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_target(tgt);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Write every register, with junk in the unused upper bits.
  task automatic load_settings(input nvp_cfg_t s);
    write_reg(REG_GAIN_PROP, s.gain_prop);
    write_reg(REG_GAIN_INTEG, s.gain_integ);
    write_reg(REG_GAIN_DERIV, s.gain_deriv);
    write_reg(REG_DRIVE_LIMIT, {2'($urandom), s.drive_limit});
    write_reg(REG_POS_UPPER, {2'($urandom), s.pos_upper});
    write_reg(REG_POS_LOWER, {1'($urandom), s.pos_lower});
    write_reg(REG_DEAD_BAND, {8'($urandom), s.dead_band});
    write_reg(REG_IDX_SPARE, 16'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  task automatic wait_drained();
    while (sb.due_q.size() != 0) @(posedge clk_i);
  endtask

  // Stop offering, let every owed result come back and the pipeline settle.
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    if ($urandom_range(3, 0) == 0)
      return GAIN_W'($urandom);
    return GAIN_W'($urandom_range(8000, 0));
  endfunction

  function automatic nvp_cfg_t pick_settings();
    nvp_cfg_t s;
    s.gain_prop   = pick_gain();
    s.gain_integ  = pick_gain();
    s.gain_deriv  = pick_gain();
    s.drive_limit = LIMIT_W'($urandom_range(TARGET_MAX, 0));
    s.pos_upper   = UPPER_W'($urandom_range(TARGET_MAX, 0));
    s.pos_lower   = LOWER_W'(-int'($urandom_range(16384, 0)));
    s.dead_band   = DBAND_W'($urandom);
    return s;
  endfunction

  // Mostly a target that wanders near the last one so the loop settles and
  // the deadband snap can fire; the rest are jumps and range extremes.
  function automatic logic [TARGET_BITS-1:0] pick_target();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 15)
      walk_tgt = $urandom_range(TARGET_MAX, 0);
    else if (roll < 22)
      walk_tgt = $urandom_range(1, 0) ? TARGET_MAX : 0;
    else if (roll < 40)
      walk_tgt = walk_tgt;
    else
      walk_tgt = walk_tgt + $urandom_range(600, 0) - 300;
    if (walk_tgt < 0)
      walk_tgt = 0;
    if (walk_tgt > TARGET_MAX)
      walk_tgt = TARGET_MAX;
    return TARGET_BITS'(walk_tgt);
  endfunction

  // Result side: random stalls per word, plus one long hold on request.
  initial begin : result_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold         = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        hold = $urandom_range(sink_idle_max, 0);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(needle_pos_o, drive_out_o);
    end
  end

  initial begin : stimulus
    nvp_cfg_t s;
    int       leftover;
    sb            = new();
    send_idle_max = 0;
    sink_idle_max = 0;
    hold_request  = 1'b0;
    n_settings    = 0;
    walk_tgt      = 0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_GAIN_PROP;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    target_rpm_i <= '0;
    out_stall_i  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: range ends and alternating bit patterns.
    offer_target(0);
    offer_target(TARGET_MAX);
    offer_target(TARGET_MAX);
    offer_target(0);
    offer_target(14'h2AAA);
    offer_target(14'h1555);
    offer_target(1);
    offer_target(1);
    finish_phase();

    // Every register at its top end; the drop to zero drives the output
    // drive far below its floor.
    s = '{gain_prop: 16'hFFFF, gain_integ: 16'hFFFF, gain_deriv: 16'hFFFF,
          drive_limit: 14'h3FFF, pos_upper: 14'h3FFF, pos_lower: -15'sd16384,
          dead_band: 8'hFF};
    load_settings(s);
    send_idle_max = IDLE_MAX;
    sink_idle_max = IDLE_MAX;
    offer_target(TARGET_MAX);
    offer_target(TARGET_MAX);
    offer_target(TARGET_MAX);
    offer_target(0);
    offer_target(0);
    offer_target(0);
    finish_phase();

    // Everything at zero: no snap, drive capped at zero.
    s = '0;
    load_settings(s);
    offer_target(TARGET_MAX);
    offer_target(50);
    offer_target(0);
    finish_phase();

    // A snap to a target above the upper bound gets clamped in the same tick.
    s = '{gain_prop: 16'd30000, gain_integ: 16'd3000, gain_deriv: 16'd0,
          drive_limit: 14'd200, pos_upper: 14'd100, pos_lower: -15'sd100,
          dead_band: 8'd255};
    load_settings(s);
    send_idle_max = 0;
    sink_idle_max = 0;
    offer_target(100);
    offer_target(100);
    offer_target(100);
    offer_target(300);
    offer_target(300);
    offer_target(340);
    finish_phase();

    // Random settings and tracking sequences, idling varied per phase.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_settings(pick_settings());
      walk_tgt      = $urandom_range(TARGET_MAX, 0);
      send_idle_max = $urandom_range(1, 0) ? IDLE_MAX : 0;
      sink_idle_max = $urandom_range(1, 0) ? IDLE_MAX : 0;
      // One phase holds the output back for a long time while words keep
      // coming, so the block backs up and stalls its input.
      if (p == 2) begin
        send_idle_max = 0;
        hold_request  = 1'b1;
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        offer_target(pick_target());
        if ($urandom_range(59, 0) == 0) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
      end
      finish_phase();
    end

    // A last pass back at the top end of every register.
    s = '{gain_prop: 16'hFFFF, gain_integ: 16'hFFFF, gain_deriv: 16'hFFFF,
          drive_limit: 14'h3FFF, pos_upper: 14'h3FFF, pos_lower: -15'sd16384,
          dead_band: 8'hFF};
    load_settings(s);
    send_idle_max = IDLE_MAX;
    sink_idle_max = IDLE_MAX;
    for (int n = 0; n < 40; n++)
      offer_target(pick_target());
    finish_phase();

    leftover = sb.due_q.size();
    $display("Ran %0d target words and checked %0d result words across %0d register settings,",
             sb.n_targets, sb.n_results, n_settings);
    $display("with random idling on both sides and one long output hold; %0d errors.",
             sb.n_errors + leftover);
    if (sb.n_errors == 0 && leftover == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
